@@ sv/bcs_pkg.sv @@
// Shared types and constants for the battery charge supervisor.
// Used by bcs_front, bcs_queue, bcs_back and battery_charge_supervisor.
// Depends on nothing.
package bcs_pkg;

  // Input commands, carried in s_tuser.
  typedef enum logic [1:0] {
    CMD_POLL       = 2'd0,
    CMD_CELL       = 2'd1,
    CMD_COUNT_FAIL = 2'd2,
    CMD_ROUND_DONE = 2'd3
  } cmd_t;

  // Result actions, carried in m_tuser.
  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_WRITE     = 2'd1,
    ACT_POWER_OFF = 2'd2
  } action_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_CAPACITY_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_CURRENT_THRESHOLD  = 3'd1;
  localparam logic [2:0] REG_CHARGE_CURRENT_SET = 3'd2;
  localparam logic [2:0] REG_CHARGE_VOLTAGE_SET = 3'd3;
  localparam logic [2:0] REG_WALL_CURRENT_SET   = 3'd4;
  localparam logic [2:0] REG_CELL_MAX_MV        = 3'd5;
  localparam logic [2:0] REG_CELL_MIN_MV        = 3'd6;
  localparam logic [2:0] REG_ERROR_LIMIT        = 3'd7;

  // Charger register masks and legal maxima.
  localparam logic [12:0] CUR_MASK  = 13'h1f80;
  localparam logic [14:0] VOLT_MASK = 15'h7ff0;
  localparam logic [12:0] CUR_MAX   = 13'd8064;
  localparam logic [14:0] VOLT_MAX  = 15'd19200;
  localparam logic [13:0] INPUT_MAX = 14'd11004;

  // Register reset values.
  localparam logic [6:0]  CAPACITY_THRESHOLD_RST = 7'd95;
  localparam logic [15:0] CURRENT_THRESHOLD_RST  = 16'd1;
  localparam logic [12:0] CHARGE_CURRENT_RST     = 13'd3000;
  localparam logic [14:0] CHARGE_VOLTAGE_RST     = 15'd12600;
  localparam logic [13:0] WALL_CURRENT_RST       = 14'd3750;
  localparam logic [14:0] CELL_MAX_RST           = 15'd4200;
  localparam logic [14:0] CELL_MIN_RST           = 15'd3000;
  localparam logic [7:0]  ERROR_LIMIT_RST        = 8'd10;

  // Job queue between the front and back parts.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One result item.
  typedef struct packed {
    action_t     action;
    logic [12:0] out_current;
    logic [14:0] out_voltage;
    logic [13:0] out_input_limit;
    logic        round_continues;
    logic        last;
  } result_t;

  // All results of one input item: one or two.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } job_t;

endpackage

@@ sv/battery_charge_supervisor.sv @@
// Top level of the battery charge supervisor: stream ports, configuration port,
// and the front part, job queue and back part. Depends on bcs_pkg, bcs_front,
// bcs_queue and bcs_back.
//
//   Channel   Direction  Handshake           Contents
//   cfg       in         cfg_write           register index and write data
//   s         in         s_tvalid/s_tready   command and gauge or cell readings
//   m         out        m_tvalid/m_tready   action and charger settings
//
// An input item is taken whenever the job queue is not full; a poll that
// zeroes the settings, or a cell sample that both powers off and stops
// charging, gives two results that leave one after the other. Results pass
// through the job queue and then the output register. The four-entry job
// queue lets the input run ahead while the output stalls; s_tready drops
// only when the queue is full. Reset is synchronous and clears the queue,
// the output and hold valid flags, the error count and the stored settings,
// and loads the configuration registers with their default values.
module battery_charge_supervisor (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // s_tdata from bit 0: capacity[6:0], capacity_ok, avg_current[15:0],
  // current_ok, cell_mv[15:0], cell_ok, six zero bits.
  input  logic [47:0] s_tdata,
  // s_tuser: command[1:0].
  input  logic [1:0]  s_tuser,
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // m_tdata from bit 0: out_current[12:0], out_voltage[14:0],
  // out_input_limit[13:0], round_continues, five zero bits.
  output logic [47:0] m_tdata,
  // m_tuser: action[1:0].
  output logic [1:0]  m_tuser,
  // m_tlast: the final result of its input item.
  output logic        m_tlast
);

  logic             accept;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_nonempty;
  bcs_pkg::job_t    push_job;
  bcs_pkg::job_t    q_head;
  bcs_pkg::result_t out_res;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  bcs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .command     (s_tuser),
    .capacity    (s_tdata[6:0]),
    .capacity_ok (s_tdata[7]),
    .avg_current (s_tdata[23:8]),
    .current_ok  (s_tdata[24]),
    .cell_mv     (s_tdata[40:25]),
    .cell_ok     (s_tdata[41]),
    .push        (push),
    .job         (push_job)
  );

  bcs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  bcs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_res    (out_res)
  );

  assign m_tdata = {5'd0, out_res.round_continues, out_res.out_input_limit,
                    out_res.out_voltage, out_res.out_current};
  assign m_tuser = out_res.action;
  assign m_tlast = out_res.last;

endmodule

@@ sv/bcs_front.sv @@
// Front part of the battery charge supervisor: configuration registers,
// charger state, error count, and the decode of each input item into a job.
// Depends on bcs_pkg.
module bcs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               accept,
  input  logic [1:0]         command,
  input  logic [6:0]         capacity,
  input  logic               capacity_ok,
  input  logic signed [15:0] avg_current,
  input  logic               current_ok,
  input  logic signed [15:0] cell_mv,
  input  logic               cell_ok,
  output logic               push,
  output bcs_pkg::job_t      job
);

  logic [6:0]         capacity_threshold;
  logic signed [15:0] current_threshold;
  logic [12:0]        charge_current_set;
  logic [14:0]        charge_voltage_set;
  logic [13:0]        wall_current_set;
  logic [14:0]        cell_max_mv;
  logic [14:0]        cell_min_mv;
  logic [7:0]         error_limit;

  logic [12:0] stored_current, stored_current_next;
  logic [14:0] stored_voltage, stored_voltage_next;
  logic [12:0] stored_input_half, stored_input_half_next;
  logic [7:0]  fault_count, fault_count_next;

  logic [1:0]         err_inc;
  logic [8:0]         err_sum;
  logic [7:0]         err_new;
  logic [6:0]         cap_eff;
  logic signed [15:0] cur_eff;
  logic               settings_idle;
  logic               settings_live;
  logic               start, in_range, over;
  logic               off, stop;
  logic [12:0]        new_current;
  logic [14:0]        new_voltage;
  logic [12:0]        new_half;
  logic [13:0]        limit_now;
  logic signed [16:0] mv_ext;
  bcs_pkg::result_t   res_off, res_stop;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_threshold <= bcs_pkg::CAPACITY_THRESHOLD_RST;
      current_threshold  <= bcs_pkg::CURRENT_THRESHOLD_RST;
      charge_current_set <= bcs_pkg::CHARGE_CURRENT_RST;
      charge_voltage_set <= bcs_pkg::CHARGE_VOLTAGE_RST;
      wall_current_set   <= bcs_pkg::WALL_CURRENT_RST;
      cell_max_mv        <= bcs_pkg::CELL_MAX_RST;
      cell_min_mv        <= bcs_pkg::CELL_MIN_RST;
      error_limit        <= bcs_pkg::ERROR_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        bcs_pkg::REG_CAPACITY_THRESHOLD: capacity_threshold <= cfg_data[6:0];
        bcs_pkg::REG_CURRENT_THRESHOLD:  current_threshold  <= cfg_data;
        bcs_pkg::REG_CHARGE_CURRENT_SET: charge_current_set <= cfg_data[12:0];
        bcs_pkg::REG_CHARGE_VOLTAGE_SET: charge_voltage_set <= cfg_data[14:0];
        bcs_pkg::REG_WALL_CURRENT_SET:   wall_current_set   <= cfg_data[13:0];
        bcs_pkg::REG_CELL_MAX_MV:        cell_max_mv        <= cfg_data[14:0];
        bcs_pkg::REG_CELL_MIN_MV:        cell_min_mv        <= cfg_data[14:0];
        bcs_pkg::REG_ERROR_LIMIT:        error_limit        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_current    <= '0;
      stored_voltage    <= '0;
      stored_input_half <= '0;
      fault_count       <= '0;
    end else if (accept) begin
      stored_current    <= stored_current_next;
      stored_voltage    <= stored_voltage_next;
      stored_input_half <= stored_input_half_next;
      fault_count       <= fault_count_next;
    end
  end

  // Readings that failed, and each count-fail command, count as errors; the count saturates at 255.
  always_comb begin
    err_inc = 2'd0;
    case (bcs_pkg::cmd_t'(command))
      bcs_pkg::CMD_POLL:       err_inc = 2'({1'b0, ~capacity_ok}) + 2'({1'b0, ~current_ok});
      bcs_pkg::CMD_CELL:       err_inc = {1'b0, ~cell_ok};
      bcs_pkg::CMD_COUNT_FAIL: err_inc = 2'd1;
      default:                 err_inc = 2'd0;
    endcase
    err_sum = {1'b0, fault_count} + {7'd0, err_inc};
    err_new = err_sum[8] ? 8'hff : err_sum[7:0];
  end

  assign cap_eff       = capacity_ok ? capacity : capacity_threshold;
  assign cur_eff       = current_ok ? avg_current : current_threshold;
  assign settings_idle = (stored_current == '0) || (stored_voltage == '0);
  assign settings_live = (stored_current != '0) || (stored_voltage != '0);
  assign start         = (cap_eff < capacity_threshold) && (cur_eff < current_threshold)
                         && settings_idle;
  assign in_range      = (charge_current_set <= bcs_pkg::CUR_MAX)
                         && (charge_voltage_set <= bcs_pkg::VOLT_MAX)
                         && (wall_current_set <= bcs_pkg::INPUT_MAX);
  assign over          = err_new > error_limit;
  assign new_current   = charge_current_set & bcs_pkg::CUR_MASK;
  assign new_voltage   = charge_voltage_set & bcs_pkg::VOLT_MASK;
  assign new_half      = wall_current_set[13:1] & bcs_pkg::CUR_MASK;
  assign limit_now     = {stored_input_half, 1'b0};

  // Cell thresholds are unsigned; compare against the signed sample at 17 bits.
  assign mv_ext = 17'(cell_mv);
  assign off    = cell_ok && (cell_mv > 16'sd0)
                  && (mv_ext < $signed({2'b00, cell_min_mv})) && settings_idle;
  assign stop   = cell_ok && (mv_ext > $signed({2'b00, cell_max_mv})) && settings_live;

  always_comb begin
    res_off          = '0;
    res_off.action   = bcs_pkg::ACT_POWER_OFF;
    res_off.last     = !stop;
    res_stop                 = '0;
    res_stop.action          = bcs_pkg::ACT_WRITE;
    res_stop.out_input_limit = limit_now;
    res_stop.last            = 1'b1;
  end

  always_comb begin
    stored_current_next    = stored_current;
    stored_voltage_next    = stored_voltage;
    stored_input_half_next = stored_input_half;
    fault_count_next       = err_new;
    push                   = 1'b0;
    job                    = '0;
    case (bcs_pkg::cmd_t'(command))
      bcs_pkg::CMD_POLL: begin
        push = accept;
        if (start) begin
          job.r0.last = 1'b1;
          if (in_range) begin
            stored_current_next    = new_current;
            stored_voltage_next    = new_voltage;
            stored_input_half_next = new_half;
            job.r0.action          = bcs_pkg::ACT_WRITE;
            job.r0.out_current     = new_current;
            job.r0.out_voltage     = new_voltage;
            job.r0.out_input_limit = {new_half, 1'b0};
          end else begin
            job.r0.action = bcs_pkg::ACT_NONE;
          end
        end else if (over) begin
          // Too many errors: zero the settings, write them, then the watchdog feed.
          stored_current_next        = '0;
          stored_voltage_next        = '0;
          job.two                    = 1'b1;
          job.r0.action              = bcs_pkg::ACT_WRITE;
          job.r0.out_input_limit     = limit_now;
          job.r1.action              = bcs_pkg::ACT_WRITE;
          job.r1.out_input_limit     = limit_now;
          job.r1.round_continues     = 1'b1;
          job.r1.last                = 1'b1;
        end else begin
          job.r0.action          = bcs_pkg::ACT_WRITE;
          job.r0.out_current     = stored_current;
          job.r0.out_voltage     = stored_voltage;
          job.r0.out_input_limit = limit_now;
          job.r0.round_continues = 1'b1;
          job.r0.last            = 1'b1;
        end
      end
      bcs_pkg::CMD_CELL: begin
        push = accept && (off || stop);
        if (stop) begin
          stored_current_next = '0;
          stored_voltage_next = '0;
        end
        if (off) begin
          job.r0  = res_off;
          job.two = stop;
          job.r1  = res_stop;
        end else begin
          job.r0 = res_stop;
        end
      end
      bcs_pkg::CMD_ROUND_DONE: fault_count_next = '0;
      default: ;
    endcase
  end

endmodule

@@ sv/bcs_queue.sv @@
// Short job queue between the front and back parts of the supervisor.
// Depends on bcs_pkg for the job type and depth.
module bcs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bcs_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          nonempty,
  output bcs_pkg::job_t head
);

  bcs_pkg::job_t mem [bcs_pkg::QDEPTH];
  logic [bcs_pkg::QAW-1:0] wr_ptr, rd_ptr;
  logic [bcs_pkg::QAW:0]   count;

  assign full     = count == (bcs_pkg::QAW+1)'(bcs_pkg::QDEPTH);
  assign nonempty = count != '0;
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/bcs_back.sv @@
// Back part of the supervisor: takes jobs from the queue and presents their
// results one at a time in an output register. Depends on bcs_pkg.
module bcs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_nonempty,
  input  bcs_pkg::job_t    q_head,
  output logic             pop,
  input  logic             out_ready,
  output logic             out_valid,
  output bcs_pkg::result_t out_res
);

  logic             hold_valid;
  bcs_pkg::result_t hold_res;
  logic             load;

  // The second result of a job waits in the hold register, so the queue
  // slot frees as soon as the first result is loaded.
  assign load = !out_valid || out_ready;
  assign pop  = load && !hold_valid && q_nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (load) begin
      if (hold_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else begin
        out_valid  <= q_nonempty;
        hold_valid <= q_nonempty && q_head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (hold_valid) begin
        out_res <= hold_res;
      end else begin
        out_res  <= q_head.r0;
        hold_res <= q_head.r1;
      end
    end
  end

endmodule
